@@ design/ipcls_pkg.sv @@
// ----------------------------------------------------------------------------
// ipcls_pkg
// Types, character codes and per-character update functions shared by the
// address text classifier.
// ----------------------------------------------------------------------------
package ipcls_pkg;

	// One input transfer: a byte of the address string plus framing
	typedef struct packed {
		logic [7:0] char_code;
		logic       end_of_address;
		logic       no_char;
	} addr_item_t;

	// One result transfer
	typedef struct packed {
		logic [1:0] verdict;
		logic       verdict_last;
	} verdict_item_t;

	// Verdict codes
	localparam logic [1:0] VERDICT_NONE = 2'd0;
	localparam logic [1:0] VERDICT_IPV4 = 2'd1;
	localparam logic [1:0] VERDICT_IPV6 = 2'd2;

	// Character codes
	localparam logic [7:0] CH_DOT   = 8'h2E;
	localparam logic [7:0] CH_COLON = 8'h3A;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;
	localparam logic [7:0] CH_LC_A  = 8'h61;
	localparam logic [7:0] CH_LC_F  = 8'h66;
	localparam logic [7:0] CH_UC_A  = 8'h41;
	localparam logic [7:0] CH_UC_F  = 8'h46;

	// Field limits
	localparam logic [2:0] DOT_FIELDS_NEEDED   = 3'd4;
	localparam logic [3:0] COLON_GROUPS_NEEDED = 4'd8;
	localparam logic [2:0] DOT_COUNT_SAT       = 3'd5;
	localparam logic [3:0] COLON_COUNT_SAT     = 4'd9;
	localparam logic [8:0] BYTE_MAX_VALUE      = 9'd255;
	localparam logic [8:0] VALUE_SAT           = 9'd256;
	localparam logic [2:0] HEX_MAX_LEN         = 3'd4;
	localparam logic [2:0] HEX_LEN_SAT         = 3'd5;

	// Decimal field reader phase
	typedef enum logic [1:0] {
		PH_SKIP   = 2'd0,
		PH_DIGITS = 2'd1,
		PH_STOP   = 2'd2
	} number_phase_t;

	// Running state for one address string
	typedef struct packed {
		logic [2:0]    dot_field_count;
		logic [3:0]    colon_group_count;
		logic          dot_fields_ok;
		logic          colon_groups_ok;
		number_phase_t number_phase;
		logic          number_negative;
		logic [8:0]    number_value;
		logic [2:0]    hex_length;
		logic          hex_group_ok;
		logic          previous_was_dot;
		logic          previous_was_colon;
		logic          string_nonempty;
	} scan_state_t;

	localparam scan_state_t SCAN_RESET = '{
		dot_field_count:    3'd0,
		colon_group_count:  4'd0,
		dot_fields_ok:      1'b1,
		colon_groups_ok:    1'b1,
		number_phase:       PH_SKIP,
		number_negative:    1'b0,
		number_value:       9'd0,
		hex_length:         3'd0,
		hex_group_ok:       1'b1,
		previous_was_dot:   1'b0,
		previous_was_colon: 1'b0,
		string_nonempty:    1'b0
	};

	// Push request from the scanner into the result queue
	typedef struct packed {
		logic [1:0]    count;
		verdict_item_t first;
		verdict_item_t second;
	} verdict_push_t;

	function automatic logic is_digit(input logic [7:0] c);
		return (c >= CH_ZERO) && (c <= CH_NINE);
	endfunction

	function automatic logic is_hex(input logic [7:0] c);
		return is_digit(c) || ((c >= CH_LC_A) && (c <= CH_LC_F)) ||
			((c >= CH_UC_A) && (c <= CH_UC_F));
	endfunction

	function automatic logic is_space(input logic [7:0] c);
		return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
	endfunction

	// Close a dot-separated field and judge its value
	function automatic scan_state_t close_dot(input scan_state_t s);
		scan_state_t r;
		r = s;
		if ((s.number_value > BYTE_MAX_VALUE) ||
				(s.number_negative && (s.number_value != 9'd0))) begin
			r.dot_fields_ok = 1'b0;
		end
		if (s.dot_field_count < DOT_COUNT_SAT) begin
			r.dot_field_count = s.dot_field_count + 3'd1;
		end
		r.number_phase    = PH_SKIP;
		r.number_negative = 1'b0;
		r.number_value    = 9'd0;
		return r;
	endfunction

	// Close a colon-separated group and judge its length and digits
	function automatic scan_state_t close_colon(input scan_state_t s);
		scan_state_t r;
		r = s;
		if (!s.hex_group_ok || (s.hex_length == 3'd0) || (s.hex_length > HEX_MAX_LEN)) begin
			r.colon_groups_ok = 1'b0;
		end
		if (s.colon_group_count < COLON_COUNT_SAT) begin
			r.colon_group_count = s.colon_group_count + 4'd1;
		end
		r.hex_length   = 3'd0;
		r.hex_group_ok = 1'b1;
		return r;
	endfunction

	// atoi-style reader: whitespace, optional sign, then digits
	function automatic scan_state_t feed_number(input scan_state_t s, input logic [7:0] c);
		scan_state_t r;
		logic        take;
		logic [11:0] prod;
		r    = s;
		take = 1'b0;
		if (s.number_phase == PH_SKIP) begin
			if (is_space(c)) begin
				take = 1'b0;
			end else if ((c == CH_PLUS) || (c == CH_MINUS)) begin
				r.number_negative = (c == CH_MINUS);
				r.number_phase    = PH_DIGITS;
			end else begin
				r.number_phase = PH_DIGITS;
				take           = 1'b1;
			end
		end else if (s.number_phase == PH_DIGITS) begin
			take = 1'b1;
		end
		prod = {3'b000, s.number_value} * 12'd10 + {8'h00, c[3:0]};
		if (take) begin
			if (is_digit(c)) begin
				r.number_value = (prod > {3'b000, VALUE_SAT}) ? VALUE_SAT : prod[8:0];
			end else begin
				r.number_phase = PH_STOP;
			end
		end
		return r;
	endfunction

	// Hex group: count characters, flag any non-hex one
	function automatic scan_state_t feed_hex(input scan_state_t s, input logic [7:0] c);
		scan_state_t r;
		r = s;
		if (s.hex_length < HEX_LEN_SAT) begin
			r.hex_length = s.hex_length + 3'd1;
		end
		if (!is_hex(c)) begin
			r.hex_group_ok = 1'b0;
		end
		return r;
	endfunction

endpackage

@@ design/ipcls_scan.sv @@
// ----------------------------------------------------------------------------
// ipcls_scan
// Per-string state register and the combinational update for one character,
// producing one or two verdicts on the end mark.
// ----------------------------------------------------------------------------
module ipcls_scan import ipcls_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	input  addr_item_t    item,
	input  logic          advance,
	output verdict_push_t push
);

	scan_state_t state_q;
	scan_state_t upd;
	scan_state_t fin;
	logic        four;
	logic        eight;
	logic [1:0]  v4_code;
	logic [1:0]  v6_code;

	// Character update, then closing of open fields at the end mark
	always_comb begin
		upd = state_q;
		if (!item.no_char) begin
			upd.string_nonempty = 1'b1;
			if (item.char_code == CH_DOT) begin
				upd = close_dot(upd);
				upd.previous_was_dot = 1'b1;
			end else begin
				upd = feed_number(upd, item.char_code);
				upd.previous_was_dot = 1'b0;
			end
			if (item.char_code == CH_COLON) begin
				upd = close_colon(upd);
				upd.previous_was_colon = 1'b1;
			end else begin
				upd = feed_hex(upd, item.char_code);
				upd.previous_was_colon = 1'b0;
			end
		end
		fin = upd;
		if (upd.string_nonempty && !upd.previous_was_dot) begin
			fin = close_dot(fin);
		end
		if (upd.string_nonempty && !upd.previous_was_colon) begin
			fin = close_colon(fin);
		end
	end

	// Verdict selection: IPv4 result goes first when both shapes match
	always_comb begin
		four    = (fin.dot_field_count == DOT_FIELDS_NEEDED);
		eight   = (fin.colon_group_count == COLON_GROUPS_NEEDED);
		v4_code = fin.dot_fields_ok ? VERDICT_IPV4 : VERDICT_NONE;
		v6_code = fin.colon_groups_ok ? VERDICT_IPV6 : VERDICT_NONE;
		push.count               = 2'd0;
		push.first.verdict       = VERDICT_NONE;
		push.first.verdict_last  = 1'b1;
		push.second.verdict      = v6_code;
		push.second.verdict_last = 1'b1;
		if (item.end_of_address) begin
			push.count = 2'd1;
			priority if (four && eight) begin
				push.count              = 2'd2;
				push.first.verdict      = v4_code;
				push.first.verdict_last = 1'b0;
			end else if (four) begin
				push.first.verdict = v4_code;
			end else if (eight) begin
				push.first.verdict = v6_code;
			end else begin
				push.first.verdict = VERDICT_NONE;
			end
		end
	end

	// State register: back to the reset value after each end mark
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= SCAN_RESET;
		end else if (advance) begin
			state_q <= item.end_of_address ? SCAN_RESET : upd;
		end
	end

endmodule

@@ design/ipcls_outq.sv @@
// ----------------------------------------------------------------------------
// ipcls_outq
// Two-entry result queue: takes up to two verdicts per cycle and presents
// them one transfer at a time, decoupling the scanner from receiver stalls.
// ----------------------------------------------------------------------------
module ipcls_outq import ipcls_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	input  verdict_push_t push,
	output logic [1:0]    space,
	output logic          result_valid,
	input  logic          result_ready,
	output verdict_item_t result
);

	verdict_item_t entry_q [2];
	logic [1:0]    count_q;
	verdict_item_t entry_d [2];
	logic [1:0]    count_d;
	logic          pop;

	assign pop          = result_valid && result_ready;
	assign result_valid = (count_q != 2'd0);
	assign result       = entry_q[0];
	// free slots once this cycle's transfer has left
	assign space        = 2'd2 - count_q + {1'b0, pop};

	// Shift out the head, then append new verdicts behind what remains
	always_comb begin
		entry_d[0] = entry_q[0];
		entry_d[1] = entry_q[1];
		count_d    = count_q;
		if (pop) begin
			entry_d[0] = entry_q[1];
			count_d    = count_q - 2'd1;
		end
		if (push.count == 2'd2) begin
			entry_d[0] = push.first;
			entry_d[1] = push.second;
			count_d    = 2'd2;
		end else if (push.count == 2'd1) begin
			if (count_d == 2'd0) begin
				entry_d[0] = push.first;
			end else begin
				entry_d[1] = push.first;
			end
			count_d = count_d + 2'd1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= 2'd0;
		end else begin
			count_q <= count_d;
		end
	end

	// Payload storage, no reset needed
	always_ff @(posedge clk) begin
		entry_q[0] <= entry_d[0];
		entry_q[1] <= entry_d[1];
	end

endmodule

@@ design/ip_address_text_classifier.sv @@
// ----------------------------------------------------------------------------
// ip_address_text_classifier
// Classifies an address string, streamed one byte per transfer, as IPv4,
// IPv6 or neither.
//
// Input channel item_valid / item_ready / item: one byte per transfer, with
// end_of_address on the last one; no_char marks a transfer without a byte
// (used to close an empty string).
// Output channel result_valid / result_ready / result: one verdict per
// transfer, verdict_last set on the final verdict of an address. A string
// that is both IPv4- and IPv6-shaped gives two verdicts, IPv4 first.
// An end-marked item is registered in the input register on transfer, scanned
// from there, and its verdicts are written into the result queue, from which
// the first one is offered.
// Throughput: one item per cycle, set by the combinational character update
// of the scanner state register; an end-marked item waits in the input
// register until the two-entry result queue has room for all its verdicts.
// Reset: clears the scanner state, the input valid flag and the queue count.
// Receiver stall: results hold in the queue; bytes keep flowing while the
// queue is full, end-marked items wait for room.
// ----------------------------------------------------------------------------
module ip_address_text_classifier import ipcls_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          item_valid,
	output logic          item_ready,
	input  addr_item_t    item,
	output logic          result_valid,
	input  logic          result_ready,
	output verdict_item_t result
);

	addr_item_t    item_s1;
	logic          valid_s1;
	logic          advance;
	logic [1:0]    space;
	verdict_push_t push_raw;
	verdict_push_t push;

	// Stage 1 advances unless its verdicts would not fit in the queue
	assign advance    = valid_s1 && (push_raw.count <= space);
	assign item_ready = !valid_s1 || advance;

	always_comb begin
		push = push_raw;
		if (!advance) begin
			push.count = 2'd0;
		end
	end

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item_ready) begin
			valid_s1 <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item_valid && item_ready) begin
			item_s1 <= item;
		end
	end

	ipcls_scan u_scan (
		.clk     (clk),
		.arst_n  (arst_n),
		.item    (item_s1),
		.advance (advance),
		.push    (push_raw)
	);

	ipcls_outq u_outq (
		.clk          (clk),
		.arst_n       (arst_n),
		.push         (push),
		.space        (space),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result)
	);

endmodule

@@ design/ipcls_checker.sv @@
// ----------------------------------------------------------------------------
// ipcls_checker
// Port-level checks for the address text classifier, bound to the top level.
// ----------------------------------------------------------------------------
module ipcls_checker import ipcls_pkg::*; (
	input logic          clk,
	input logic          arst_n,
	input logic          item_valid,
	input logic          item_ready,
	input addr_item_t    item,
	input logic          result_valid,
	input logic          result_ready,
	input verdict_item_t result
);

	// A stalled transfer stays offered
	a_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> result_valid)
		else $error("result_valid dropped while stalled");

	// A stalled transfer keeps its payload
	a_hold_data: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> $stable(result))
		else $error("result changed while stalled");

	// Only defined verdict codes appear
	a_code: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> (result.verdict == VERDICT_NONE) ||
			(result.verdict == VERDICT_IPV4) || (result.verdict == VERDICT_IPV6))
		else $error("undefined verdict code");

	// A non-final verdict, the IPv4 one of a pair, is never an IPv6 verdict
	a_first_of_pair: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result.verdict_last |-> result.verdict != VERDICT_IPV6)
		else $error("IPv6 verdict not last");

	// The second verdict of a pair follows straight after the first
	a_pair_follows: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_ready && !result.verdict_last |=> result_valid)
		else $error("second verdict missing");

endmodule

bind ip_address_text_classifier ipcls_checker u_ipcls_checker (.*);
